>>> sv/midpoint_circle_rasterizer_unit_assert.svh
// assertion macros shared by the checker of the circle rasterizer
`ifndef MIDPOINT_CIRCLE_RASTERIZER_UNIT_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_UNIT_ASSERT_SVH

// clocked check, switched off while reset is held
`define MCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define MCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/mcr_pkg.sv
// package: shared types and constants of the circle rasterizer
`default_nettype none

package mcr_pkg;

    // default sizes
    localparam int DEF_COORD_BITS  = 16;
    localparam int DEF_RADIUS_BITS = 12;

    // item mode codes
    localparam int MODE_BITS = 2;
    typedef logic [MODE_BITS-1:0] t_mode;
    localparam t_mode MODE_START_OUTLINE = 2'd0;
    localparam t_mode MODE_START_FILL    = 2'd1;

    // result index within one step item
    localparam int IDX_BITS = 3;
    localparam logic [IDX_BITS-1:0] LAST_IDX_DONE    = 3'd0;
    localparam logic [IDX_BITS-1:0] LAST_IDX_FILL    = 3'd3;
    localparam logic [IDX_BITS-1:0] LAST_IDX_OUTLINE = 3'd7;

    // kind of result burst handed to the emitter
    typedef enum logic [1:0] {
        KIND_DONE,
        KIND_FILL,
        KIND_OUTLINE
    } t_kind;

    // job control from the step logic to the emitter
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_job_ctl;

endpackage

`default_nettype wire

>>> sv/mcr_in_if.sv
// interface: input item channel of the circle rasterizer
`default_nettype none

interface mcr_in_if #(
    parameter int COORD_BITS  = mcr_pkg::DEF_COORD_BITS,
    parameter int RADIUS_BITS = mcr_pkg::DEF_RADIUS_BITS
);
    logic                          valid;
    logic                          ready;
    mcr_pkg::t_mode                mode;
    logic signed [COORD_BITS-1:0]  centre_col;
    logic signed [COORD_BITS-1:0]  centre_row;
    logic        [RADIUS_BITS-1:0] radius;

    modport source (output valid, mode, centre_col, centre_row, radius, input ready);
    modport sink   (input valid, mode, centre_col, centre_row, radius, output ready);
endinterface

`default_nettype wire

>>> sv/mcr_out_if.sv
// interface: result item channel of the circle rasterizer
`default_nettype none

interface mcr_out_if #(
    parameter int OUT_BITS = mcr_pkg::DEF_COORD_BITS + 1
);
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] x_left;
    logic signed [OUT_BITS-1:0] x_right;
    logic signed [OUT_BITS-1:0] row_y;
    logic                       last_of_step;
    logic                       done_res;

    modport source (output valid, x_left, x_right, row_y, last_of_step, done_res,
                    input ready);
    modport sink   (input valid, x_left, x_right, row_y, last_of_step, done_res,
                    output ready);
endinterface

`default_nettype wire

>>> sv/midpoint_circle_rasterizer_unit.sv
// top level of the midpoint circle rasterizer
//
//  channel  direction  carries                                   handshake
//  i_in     in         mode, centre_col, centre_row, radius      valid / ready
//  o_res    out        x_left, x_right, row_y, last_of_step,     valid / ready
//                      done_res
//
// a start item gives no result and does not wait for the emitter; a new item can follow at once
// a step item gives 8 results on the result port (outline), 4 (filled) or 1 (done),
// sent by the emitter one result per cycle while the result port is ready
// the input register takes the next item while the emitter still drains a pass
// synchronous active-low reset empties both stages and clears the circle state
// a stalled result port holds its item and backs up into the input register
`default_nettype none

module midpoint_circle_rasterizer_unit #(
    parameter int COORD_BITS  = mcr_pkg::DEF_COORD_BITS,
    parameter int RADIUS_BITS = mcr_pkg::DEF_RADIUS_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mcr_in_if.sink    i_in,
    mcr_out_if.source o_res
);
    import mcr_pkg::*;

    t_job_ctl                      job_ctl;
    logic signed [COORD_BITS-1:0]  job_cx;
    logic signed [COORD_BITS-1:0]  job_cy;
    logic signed [RADIUS_BITS+1:0] job_a;
    logic signed [RADIUS_BITS+1:0] job_b;
    logic                          emit_free;

    // step logic and circle state
    mcr_core #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_emit_free (emit_free),
        .o_job_ctl   (job_ctl),
        .o_job_cx    (job_cx),
        .o_job_cy    (job_cy),
        .o_job_a     (job_a),
        .o_job_b     (job_b)
    );

    // result emitter
    mcr_emit #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_ctl (job_ctl),
        .i_job_cx  (job_cx),
        .i_job_cy  (job_cy),
        .i_job_a   (job_a),
        .i_job_b   (job_b),
        .o_free    (emit_free),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

>>> sv/mcr_core.sv
// input register, circle state and one pass of the midpoint recurrence
`default_nettype none

module mcr_core #(
    parameter int COORD_BITS  = mcr_pkg::DEF_COORD_BITS,
    parameter int RADIUS_BITS = mcr_pkg::DEF_RADIUS_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    mcr_in_if.sink                             i_in,
    input  wire logic                          i_emit_free,
    output mcr_pkg::t_job_ctl                  o_job_ctl,
    output logic signed [COORD_BITS-1:0]       o_job_cx,
    output logic signed [COORD_BITS-1:0]       o_job_cy,
    output logic signed [RADIUS_BITS+1:0]      o_job_a,
    output logic signed [RADIUS_BITS+1:0]      o_job_b
);
    import mcr_pkg::*;

    localparam int OFF_BITS = RADIUS_BITS + 2;
    localparam int DEC_BITS = RADIUS_BITS + 4;
    localparam logic signed [DEC_BITS-1:0] DEC_ZERO = DEC_BITS'(0);
    localparam logic signed [DEC_BITS-1:0] DEC_ONE = DEC_BITS'(1);
    localparam logic signed [DEC_BITS-1:0] DEC_TWO = DEC_BITS'(2);
    localparam logic signed [OFF_BITS-1:0] OFF_ONE = OFF_BITS'(1);

    // input register
    logic                          r_in_valid;
    t_mode                         r_mode;
    logic signed [COORD_BITS-1:0]  r_in_cx;
    logic signed [COORD_BITS-1:0]  r_in_cy;
    logic        [RADIUS_BITS-1:0] r_in_rad;

    // circle state
    logic                          r_active, n_active;
    logic                          r_fill, n_fill;
    logic signed [COORD_BITS-1:0]  r_cx, n_cx;
    logic signed [COORD_BITS-1:0]  r_cy, n_cy;
    logic        [RADIUS_BITS-1:0] r_rad, n_rad;
    logic signed [OFF_BITS-1:0]    r_a, n_a;
    logic signed [OFF_BITS-1:0]    r_b, n_b;
    logic signed [DEC_BITS-1:0]    r_dec, n_dec;
    logic signed [DEC_BITS-1:0]    r_osm, n_osm;
    logic signed [DEC_BITS-1:0]    r_osn, n_osn;

    logic                          is_start;
    logic                          advance;
    logic                          loop_end;
    logic signed [OFF_BITS-1:0]    in_rad_o;
    logic signed [DEC_BITS-1:0]    in_rad_d;
    logic signed [DEC_BITS-1:0]    rad_d;
    logic signed [DEC_BITS-1:0]    a_d;
    logic signed [DEC_BITS-1:0]    b_d;
    logic signed [DEC_BITS-1:0]    dec_mid;
    logic signed [DEC_BITS-1:0]    osm_inc;

    // handshake: a start item always moves on, a step waits for the emitter
    assign is_start   = r_mode inside {MODE_START_OUTLINE, MODE_START_FILL};
    assign advance    = r_in_valid && (is_start || i_emit_free);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_mode   <= i_in.mode;
            r_in_cx  <= i_in.centre_col;
            r_in_cy  <= i_in.centre_row;
            r_in_rad <= i_in.radius;
        end
    end

    // widened operands
    assign in_rad_o = signed'({2'b00, r_in_rad});
    assign in_rad_d = signed'({4'b0000, r_in_rad});
    assign rad_d    = signed'({4'b0000, r_rad});
    assign a_d      = {{(DEC_BITS-OFF_BITS){r_a[OFF_BITS-1]}}, r_a};
    assign b_d      = {{(DEC_BITS-OFF_BITS){r_b[OFF_BITS-1]}}, r_b};
    assign loop_end = !r_active || (r_a < r_b);
    assign osm_inc  = r_osm + DEC_TWO;
    assign dec_mid  = (r_dec <= DEC_ZERO) ? (r_dec + r_osn) : r_dec;

    // next circle state
    always_comb begin
        n_active = r_active;
        n_fill   = r_fill;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_rad    = r_rad;
        n_a      = r_a;
        n_b      = r_b;
        n_dec    = r_dec;
        n_osm    = r_osm;
        n_osn    = r_osn;
        if (advance) begin
            if (is_start) begin
                n_cx     = r_in_cx;
                n_cy     = r_in_cy;
                n_rad    = r_in_rad;
                n_fill   = (r_mode == MODE_START_FILL);
                n_active = 1'b1;
                n_b      = '0;
                n_osm    = DEC_ONE;
                n_osn    = DEC_ONE;
                if (r_mode == MODE_START_FILL) begin
                    n_a   = in_rad_o;
                    n_dec = in_rad_d - DEC_ONE;
                end else begin
                    n_a   = in_rad_o - OFF_ONE;
                    n_dec = DEC_ONE - (in_rad_d <<< 1);
                end
            end else if (loop_end) begin
                n_active = 1'b0;
            end else if (r_fill) begin
                // three-branch decision for the filled circle
                if (r_dec >= (b_d <<< 1)) begin
                    n_dec = r_dec - (b_d <<< 1) - DEC_ONE;
                    n_b   = r_b + OFF_ONE;
                end else if (r_dec < ((rad_d - a_d) <<< 1)) begin
                    n_dec = r_dec + (a_d <<< 1) - DEC_ONE;
                    n_a   = r_a - OFF_ONE;
                end else begin
                    n_dec = r_dec + ((a_d - b_d - DEC_ONE) <<< 1);
                    n_a   = r_a - OFF_ONE;
                    n_b   = r_b + OFF_ONE;
                end
            end else begin
                // error and odd-step recurrence for the outline
                if (r_dec <= DEC_ZERO) begin
                    n_b   = r_b + OFF_ONE;
                    n_osn = r_osn + DEC_TWO;
                end
                if (dec_mid > DEC_ZERO) begin
                    n_a   = r_a - OFF_ONE;
                    n_osm = osm_inc;
                    n_dec = dec_mid + osm_inc - (rad_d <<< 1);
                end else begin
                    n_dec = dec_mid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_fill   <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_rad    <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_dec    <= '0;
            r_osm    <= DEC_ONE;
            r_osn    <= DEC_ONE;
        end else begin
            r_active <= n_active;
            r_fill   <= n_fill;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_rad    <= n_rad;
            r_a      <= n_a;
            r_b      <= n_b;
            r_dec    <= n_dec;
            r_osm    <= n_osm;
            r_osn    <= n_osn;
        end
    end

    // job for the emitter, taken from the state before this pass
    always_comb begin
        o_job_ctl.valid = r_in_valid && !is_start;
        if (loop_end) begin
            o_job_ctl.kind = KIND_DONE;
        end else if (r_fill) begin
            o_job_ctl.kind = KIND_FILL;
        end else begin
            o_job_ctl.kind = KIND_OUTLINE;
        end
    end

    assign o_job_cx = r_cx;
    assign o_job_cy = r_cy;
    assign o_job_a  = r_a;
    assign o_job_b  = r_b;

endmodule

`default_nettype wire

>>> sv/mcr_emit.sv
// result emitter: walks the points or spans of one pass, one item per cycle while the result port is ready
`default_nettype none

module mcr_emit #(
    parameter int COORD_BITS  = mcr_pkg::DEF_COORD_BITS,
    parameter int RADIUS_BITS = mcr_pkg::DEF_RADIUS_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mcr_pkg::t_job_ctl             i_job_ctl,
    input  wire logic signed [COORD_BITS-1:0]  i_job_cx,
    input  wire logic signed [COORD_BITS-1:0]  i_job_cy,
    input  wire logic signed [RADIUS_BITS+1:0] i_job_a,
    input  wire logic signed [RADIUS_BITS+1:0] i_job_b,
    output logic                               o_free,
    mcr_out_if.source                          o_res
);
    import mcr_pkg::*;

    localparam int OFF_BITS = RADIUS_BITS + 2;
    localparam int OUT_BITS = COORD_BITS + 1;
    localparam int SUM_BITS = ((COORD_BITS > OFF_BITS) ? COORD_BITS : OFF_BITS) + 1;

    logic                         r_valid;
    t_kind                        r_kind;
    logic [IDX_BITS-1:0]          r_idx;
    logic signed [COORD_BITS-1:0] r_cx;
    logic signed [COORD_BITS-1:0] r_cy;
    logic signed [OFF_BITS-1:0]   r_a;
    logic signed [OFF_BITS-1:0]   r_b;

    logic [IDX_BITS-1:0]          last_idx;
    logic                         is_last;
    logic                         load;
    logic                         swap;
    logic signed [OFF_BITS-1:0]   u;
    logic signed [OFF_BITS-1:0]   v;
    logic signed [SUM_BITS-1:0]   cx_s;
    logic signed [SUM_BITS-1:0]   cy_s;
    logic signed [SUM_BITS-1:0]   u_s;
    logic signed [SUM_BITS-1:0]   v_s;
    logic signed [SUM_BITS-1:0]   x_minus;
    logic signed [SUM_BITS-1:0]   x_plus;
    logic signed [SUM_BITS-1:0]   y_minus;
    logic signed [SUM_BITS-1:0]   y_plus;

    // burst length by kind
    always_comb begin
        case (r_kind)
            KIND_FILL:    last_idx = LAST_IDX_FILL;
            KIND_OUTLINE: last_idx = LAST_IDX_OUTLINE;
            default:      last_idx = LAST_IDX_DONE;
        endcase
    end

    assign is_last = (r_idx == last_idx);
    assign o_free  = !r_valid || (o_res.ready && is_last);
    assign load    = i_job_ctl.valid && o_free;

    // burst sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_kind  <= KIND_DONE;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_kind  <= i_job_ctl.kind;
            r_idx   <= '0;
        end else if (r_valid && o_res.ready) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    // snapshot of the pass geometry
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cx <= i_job_cx;
            r_cy <= i_job_cy;
            r_a  <= i_job_a;
            r_b  <= i_job_b;
        end
    end

    // offsets swap for the steep octants and the top and bottom spans
    assign swap = (r_kind == KIND_OUTLINE) ? r_idx[2] : (r_idx[0] ^ r_idx[1]);
    assign u    = swap ? r_b : r_a;
    assign v    = swap ? r_a : r_b;

    assign cx_s    = {{(SUM_BITS-COORD_BITS){r_cx[COORD_BITS-1]}}, r_cx};
    assign cy_s    = {{(SUM_BITS-COORD_BITS){r_cy[COORD_BITS-1]}}, r_cy};
    assign u_s     = {{(SUM_BITS-OFF_BITS){u[OFF_BITS-1]}}, u};
    assign v_s     = {{(SUM_BITS-OFF_BITS){v[OFF_BITS-1]}}, v};
    assign x_minus = cx_s - u_s;
    assign x_plus  = cx_s + u_s;
    assign y_minus = cy_s - v_s;
    assign y_plus  = cy_s + v_s;

    // result payload
    always_comb begin
        o_res.valid        = r_valid;
        o_res.last_of_step = is_last;
        o_res.done_res     = (r_kind == KIND_DONE);
        case (r_kind)
            KIND_FILL: begin
                o_res.x_left  = x_minus[OUT_BITS-1:0];
                o_res.x_right = x_plus[OUT_BITS-1:0];
                o_res.row_y   = r_idx[1] ? y_minus[OUT_BITS-1:0] : y_plus[OUT_BITS-1:0];
            end
            KIND_OUTLINE: begin
                o_res.x_left  = r_idx[1] ? x_minus[OUT_BITS-1:0] : x_plus[OUT_BITS-1:0];
                o_res.x_right = r_idx[1] ? x_minus[OUT_BITS-1:0] : x_plus[OUT_BITS-1:0];
                o_res.row_y   = r_idx[0] ? y_plus[OUT_BITS-1:0] : y_minus[OUT_BITS-1:0];
            end
            default: begin
                o_res.x_left  = '0;
                o_res.x_right = '0;
                o_res.row_y   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/mcr_checker.sv
// checker on the result port of the circle rasterizer, with its bind
`default_nettype none

module mcr_checker #(
    parameter int OUT_BITS = mcr_pkg::DEF_COORD_BITS + 1
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic signed [OUT_BITS-1:0] i_x_left,
    input wire logic signed [OUT_BITS-1:0] i_x_right,
    input wire logic signed [OUT_BITS-1:0] i_row_y,
    input wire logic                       i_last_of_step,
    input wire logic                       i_done_res
);
`include "midpoint_circle_rasterizer_unit_assert.svh"

    // a stalled result keeps its item
    `MCR_ASSERT(a_stall_holds, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_x_left) && $stable(i_x_right) && $stable(i_row_y) && $stable(i_last_of_step) && $stable(i_done_res)), "stalled result item changed")

    // a done item stands alone and carries no geometry
    `MCR_ASSERT(a_done_alone, (i_out_valid && i_done_res) |-> (i_last_of_step && (i_x_left == '0) && (i_x_right == '0) && (i_row_y == '0)), "done item malformed")

    // a pass is not cut short: more geometry follows a taken non-final item
    `MCR_ASSERT(a_pass_continues, (i_out_valid && i_out_ready && !i_last_of_step) |=> (i_out_valid && !i_done_res), "pass ended early")

    // reset empties the result port
    `MCR_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker #(
    .OUT_BITS (COORD_BITS + 1)
) u_mcr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_x_left       (o_res.x_left),
    .i_x_right      (o_res.x_right),
    .i_row_y        (o_res.row_y),
    .i_last_of_step (o_res.last_of_step),
    .i_done_res     (o_res.done_res)
);

`default_nettype wire
